// ===== sv/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with index access.
// No dependencies; imported by the deque, its scoreboard and the testbench top.
package bdq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_VALUE_BITS = 64;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 4;
    localparam int ITEM_W   = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_IDX   = 3'd4,
        ACT_WRITE_IDX  = 3'd5,
        ACT_SIZE       = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

// ===== sv/bounded_deque_with_index_access.sv =====
// Bounded double-ended queue kept as a ring in one synchronous memory.
// The result strobe o_done rises in the cycle after the start transfer.
// Throughput: one action per cycle; busy stays low. Results come from the memory's
// registered read port; writes land at the transfer edge.
// Reset (i_rst_n low, synchronous) empties the queue; slot contents are kept.
// Results cannot be stalled: each one is on the ports for a single cycle.
module bounded_deque_with_index_access
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_position,
    input  logic [ITEM_W-1:0]   i_item_value,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [ITEM_W-1:0]   o_result_value,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW:0]   CAP_W   = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_SL = SW'(CAPACITY - 1);

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    logic [SW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_done;
    t_status               r_status, n_status;
    logic                  r_use_data, n_use_data;
    logic [VALUE_BITS-1:0] r_rd_data;

    t_action               act;
    logic                  accept;
    logic                  full, empty, pos_ok;
    logic [CW-1:0]         ring_off;
    logic [CW:0]           ring_sum;
    logic [SW-1:0]         ring_slot;
    logic [SW-1:0]         front_dec;
    logic [SW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [CMPW-1:0]       pos_ext, cnt_ext;
    logic [ITEM_W-1:0]     data_ext;
    logic [CW+COUNT_W-1:0] cnt_out;

    assign busy   = 1'b0;
    assign accept = start;
    assign act    = t_action'(i_action);

    assign full    = (r_count == CAP_C);
    assign empty   = (r_count == '0);
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);
    assign pos_ok  = (pos_ext < cnt_ext);

    assign front_dec = (r_front == '0) ? LAST_SL : r_front - 1'b1;

    // Offset is always below CAPACITY when used, so one subtract wraps it.
    always_comb begin
        case (act)
            ACT_PUSH_BACK: ring_off = r_count;
            ACT_POP_FRONT: ring_off = CW'(1);
            ACT_POP_BACK:  ring_off = r_count - 1'b1;
            default:       ring_off = CW'(i_position);
        endcase
        ring_sum = (CW+1)'(r_front) + (CW+1)'(ring_off);
        if (ring_sum >= CAP_W) begin
            ring_sum = ring_sum - CAP_W;
        end
        ring_slot = ring_sum[SW-1:0];
    end

    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_status   = ST_OK;
        n_use_data = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = ring_slot;
        rd_addr    = ring_slot;
        unique case (act)
            ACT_PUSH_FRONT: begin
                wr_addr = front_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = accept;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = accept;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                rd_addr = r_front;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_data = 1'b1;
                    n_front    = ring_slot;
                    n_count    = r_count - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_data = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            ACT_READ_IDX: begin
                if (!pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_use_data = 1'b1;
                end
            end
            ACT_WRITE_IDX: begin
                if (!pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    wr_en = accept;
                end
            end
            default: begin
                // size and the unused code leave everything as it is
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_item_value[VALUE_BITS-1:0];
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_use_data <= n_use_data;
        end
    end

    always_comb begin
        data_ext                   = '0;
        data_ext[VALUE_BITS-1:0]   = r_rd_data;
    end

    assign cnt_out        = (CW+COUNT_W)'(r_count);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_value = r_use_data ? data_ext : '0;
    assign o_count        = cnt_out[COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_count) <= CAP_W)
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted action produced no result");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK)
        |=> o_status == ST_FULL && $stable(r_count) && $stable(r_front))
        else $error("push on full queue changed state");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && empty && (act == ACT_POP_FRONT || act == ACT_POP_BACK)
        |=> o_status == ST_EMPTY && $stable(r_count))
        else $error("pop on empty queue changed state");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_result_value == '0)
        else $error("nonzero value with error status");

endmodule

// ===== tb/bdq_scoreboard.sv =====
// Scoreboard for the bounded deque: watches the start and done channels, keeps its own
// ring model, predicts every result and compares it field by field.
// Depends on bdq_pkg for the action and status codes.
module bdq_scoreboard
    import bdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_position,
    input  logic [ITEM_W-1:0]   i_item_value,
    input  logic                i_done,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [ITEM_W-1:0]   i_result_value,
    input  logic [COUNT_W-1:0]  i_count,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_CAPACITY;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_status             status;
        logic [ITEM_W-1:0]   value;
        logic [COUNT_W-1:0]  count;
    } t_deque_result;

    logic [ITEM_W-1:0]  slot_mem [DEPTH];
    logic [POS_W-1:0]   head_slot;
    logic [COUNT_W-1:0] fill_level;
    t_deque_result      expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        head_slot = '0;
        fill_level = '0;
    end

    function automatic int ring_index(int offset);
        return (int'(head_slot) + offset) % DEPTH;
    endfunction

    // Applies one action to the model deque and returns the result it should produce.
    function automatic t_deque_result apply_action(logic [ACTION_W-1:0] act,
                                                   logic [POS_W-1:0] pos,
                                                   logic [ITEM_W-1:0] val);
        t_deque_result res;
        res.status = ST_OK;
        res.value = '0;
        case (t_action'(act))
            ACT_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot = POS_W'(ring_index(DEPTH - 1));
                    slot_mem[head_slot] = val;
                    fill_level = fill_level + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot_mem[ring_index(int'(fill_level))] = val;
                    fill_level = fill_level + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = slot_mem[head_slot];
                    head_slot = POS_W'(ring_index(1));
                    fill_level = fill_level - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = slot_mem[ring_index(int'(fill_level) - 1)];
                    fill_level = fill_level - 1'b1;
                end
            end
            ACT_READ_IDX: begin
                if (pos >= fill_level)
                    res.status = ST_RANGE;
                else
                    res.value = slot_mem[ring_index(int'(pos))];
            end
            ACT_WRITE_IDX: begin
                if (pos >= fill_level)
                    res.status = ST_RANGE;
                else
                    slot_mem[ring_index(int'(pos))] = val;
            end
            default: ;  // size and the unused code change nothing
        endcase
        res.count = fill_level;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            head_slot = '0;
            fill_level = '0;
            expected_results.delete();
        end else begin
            // result of the previous transfer is checked before this edge's transfer is queued
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d value=%h count=%0d",
                                 $realtime, i_status, i_result_value, i_count);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status || i_result_value !== want.value ||
                            i_count !== want.count) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display("%0t: mismatch exp status=%0d value=%h count=%0d",
                                     $realtime, want.status, want.value, want.count,
                                     " got status=%0d value=%h count=%0d",
                                     i_status, i_result_value, i_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_action(i_action, i_position, i_item_value));
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/bounded_deque_with_index_access_test.sv =====
// Top of the deque testbench: clock, reset, directed and random action stimulus, verdict.
// Depends on bdq_pkg, bounded_deque_with_index_access and bdq_scoreboard.
module bounded_deque_with_index_access_test
    import bdq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int CHUNKS = 34;
    localparam int CHUNK_ITEMS = 50;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [ITEM_W-1:0] ALL_ONES = '1;

    typedef enum int { MODE_FILL, MODE_MIX, MODE_DRAIN } t_mix_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action_in;
    logic [POS_W-1:0]    position_in;
    logic [ITEM_W-1:0]   value_in;
    logic                done;
    logic [STATUS_W-1:0] status_out;
    logic [ITEM_W-1:0]   value_out;
    logic [COUNT_W-1:0]  count_out;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;

    bounded_deque_with_index_access i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (action_in),
        .i_position     (position_in),
        .i_item_value   (value_in),
        .o_done         (done),
        .o_status       (status_out),
        .o_result_value (value_out),
        .o_count        (count_out)
    );

    bdq_scoreboard i_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (action_in),
        .i_position     (position_in),
        .i_item_value   (value_in),
        .i_done         (done),
        .i_status       (status_out),
        .i_result_value (value_out),
        .i_count        (count_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // starts low so the first rising edge comes after reset is driven
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Holds start high until the transfer edge; returns at that edge.
    task automatic issue(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                         logic [ITEM_W-1:0] val);
        start <= 1'b1;
        action_in <= act;
        position_in <= pos;
        value_in <= val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [ITEM_W-1:0] rand_value();
        int r;
        r = $urandom_range(15);
        if (r == 0) return '0;
        if (r == 1) return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // Mode weights push the fill level toward full, empty or the middle.
    function automatic logic [ACTION_W-1:0] pick_action(t_mix_mode mode);
        int r;
        int lim[7];
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:  lim = '{35, 70, 78, 86, 91, 96, 98};
            MODE_DRAIN: lim = '{8, 16, 46, 76, 86, 94, 98};
            default:    lim = '{15, 30, 45, 60, 78, 93, 98};
        endcase
        if (r < lim[0]) return ACT_PUSH_FRONT;
        if (r < lim[1]) return ACT_PUSH_BACK;
        if (r < lim[2]) return ACT_POP_FRONT;
        if (r < lim[3]) return ACT_POP_BACK;
        if (r < lim[4]) return ACT_READ_IDX;
        if (r < lim[5]) return ACT_WRITE_IDX;
        if (r < lim[6]) return ACT_SIZE;
        return ACT_UNUSED;
    endfunction

    initial begin
        t_mix_mode mode;
        bit quiet;
        start <= 1'b0;
        i_rst_n <= 1'b0;
        action_in <= ACT_SIZE;
        position_in <= '0;
        value_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-queue corner cases
        issue(ACT_POP_FRONT, 4'd0, '0);
        issue(ACT_POP_BACK, 4'd0, '0);
        issue(ACT_READ_IDX, 4'd0, '0);
        issue(ACT_WRITE_IDX, 4'd15, ALL_ONES);
        issue(ACT_UNUSED, 4'd15, ALL_ONES);
        // fill to capacity from both ends, wrapping the head below slot zero
        for (int i = 0; i < DEF_CAPACITY; i++) begin
            logic [ITEM_W-1:0] v;
            case (i % 4)
                0: v = '0;
                1: v = ALL_ONES;
                2: v = {32{2'b01}};
                default: v = {32{2'b10}};
            endcase
            issue((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, 4'(i), v);
        end
        issue(ACT_PUSH_FRONT, 4'd0, ALL_ONES);
        issue(ACT_PUSH_BACK, 4'd0, ALL_ONES);
        issue(ACT_WRITE_IDX, 4'd15, {32'h0123_4567, 32'h89ab_cdef});
        issue(ACT_READ_IDX, 4'd15, '0);

        for (int c = 0; c < CHUNKS; c++) begin
            case (c % 4)
                0: mode = MODE_FILL;
                1: mode = MODE_MIX;
                2: mode = MODE_DRAIN;
                default: mode = t_mix_mode'($urandom_range(2));
            endcase
            quiet = ($urandom_range(3) == 0);
            if (c % 5 == 4)
                wait_drained();
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                issue(pick_action(mode), 4'($urandom_range(15)), rand_value());
                if (!quiet)
                    idle(gap_len());
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bdq_pkg.sv
sv/bounded_deque_with_index_access.sv
tb/bdq_scoreboard.sv
tb/bounded_deque_with_index_access_test.sv
